>>> rtl/c2d_pkg.sv
// ---------------------------------------------------------------------------
// c2d_pkg
// Shared types, codes and constants of the padded, strided 2d convolution.
// ---------------------------------------------------------------------------
package c2d_pkg;

  // default store sizing, handed to the top level parameters
  localparam int DEF_MAX_CHANNELS   = 4;
  localparam int DEF_MAX_IMAGE_DIM  = 32;
  localparam int DEF_MAX_KERNELS    = 8;
  localparam int DEF_MAX_KERNEL_DIM = 5;

  localparam int STRIDE_MAX = 4;
  localparam int PAD_MAX    = 4;

  localparam int VAL_W = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W = 40;
  // enough headroom for the largest tap count at the widest parameters
  localparam int ACC_W = 44;
  // signed coordinate width for row*stride - pad + tap
  localparam int CRD_W = 11;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_STEP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_AMOUNT    = 3'd7;

  localparam logic [2:0] RST_CHANNEL_COUNT = 3'd1;
  localparam logic [5:0] RST_IMAGE_HEIGHT  = 6'd32;
  localparam logic [5:0] RST_IMAGE_WIDTH   = 6'd32;
  localparam logic [3:0] RST_KERNEL_COUNT  = 4'd1;
  localparam logic [2:0] RST_KERNEL_HEIGHT = 3'd3;
  localparam logic [2:0] RST_KERNEL_WIDTH  = 3'd3;
  localparam logic [2:0] RST_STRIDE_STEP   = 3'd1;
  localparam logic [2:0] RST_PAD_AMOUNT    = 3'd0;

  localparam logic [1:0] REQ_LOAD_IMG = 2'd0;
  localparam logic [1:0] REQ_LOAD_WGT = 2'd1;
  localparam logic [1:0] REQ_COMPUTE  = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [1:0]              channel_sel;
    logic [2:0]              kernel_sel;
    logic [5:0]              row_pos;
    logic [5:0]              col_pos;
    logic signed [VAL_W-1:0] load_value;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    status;
  } out_res_t;

  // configuration as used, each field saturated into its legal range
  typedef struct packed {
    logic [2:0] nc;
    logic [5:0] ih;
    logic [5:0] iw;
    logic [3:0] nk;
    logic [2:0] kh;
    logic [2:0] kw;
    logic [2:0] st;
    logic [2:0] pd;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic tap_last;
  } mac_ctl_t;

  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] sum;
  } mac_stat_t;

  function automatic int clampu(input int v, input int lo, input int hi);
    int r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

>>> rtl/c2d_if.sv
// ---------------------------------------------------------------------------
// c2d request and result channels
// Valid/ready channels carrying one request or one result item.
// ---------------------------------------------------------------------------
interface c2d_in_if import c2d_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c2d_out_if import c2d_pkg::*; ();
  logic     valid;
  logic     ready;
  out_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/c2d_ram.sv
// ---------------------------------------------------------------------------
// c2d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/c2d_cfg.sv
// ---------------------------------------------------------------------------
// c2d_cfg
// Configuration registers with saturation of each value into its range.
// ---------------------------------------------------------------------------
module c2d_cfg import c2d_pkg::*; #(
  parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
  parameter int MAX_IMAGE_DIM  = DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNELS    = DEF_MAX_KERNELS,
  parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [2:0] nc_r;
  logic [5:0] ih_r;
  logic [5:0] iw_r;
  logic [3:0] nk_r;
  logic [2:0] kh_r;
  logic [2:0] kw_r;
  logic [2:0] st_r;
  logic [2:0] pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= RST_CHANNEL_COUNT;
      ih_r <= RST_IMAGE_HEIGHT;
      iw_r <= RST_IMAGE_WIDTH;
      nk_r <= RST_KERNEL_COUNT;
      kh_r <= RST_KERNEL_HEIGHT;
      kw_r <= RST_KERNEL_WIDTH;
      st_r <= RST_STRIDE_STEP;
      pd_r <= RST_PAD_AMOUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: nc_r <= cfg_wdata[2:0];
        CFG_IMAGE_HEIGHT:  ih_r <= cfg_wdata[5:0];
        CFG_IMAGE_WIDTH:   iw_r <= cfg_wdata[5:0];
        CFG_KERNEL_COUNT:  nk_r <= cfg_wdata[3:0];
        CFG_KERNEL_HEIGHT: kh_r <= cfg_wdata[2:0];
        CFG_KERNEL_WIDTH:  kw_r <= cfg_wdata[2:0];
        CFG_STRIDE_STEP:   st_r <= cfg_wdata[2:0];
        CFG_PAD_AMOUNT:    pd_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.nc = 3'(clampu(int'(nc_r), 1, MAX_CHANNELS));
    cfg.ih = 6'(clampu(int'(ih_r), 1, MAX_IMAGE_DIM));
    cfg.iw = 6'(clampu(int'(iw_r), 1, MAX_IMAGE_DIM));
    cfg.nk = 4'(clampu(int'(nk_r), 1, MAX_KERNELS));
    cfg.kh = 3'(clampu(int'(kh_r), 1, MAX_KERNEL_DIM));
    cfg.kw = 3'(clampu(int'(kw_r), 1, MAX_KERNEL_DIM));
    cfg.st = 3'(clampu(int'(st_r), 1, STRIDE_MAX));
    cfg.pd = 3'(clampu(int'(pd_r), 0, PAD_MAX));
  end

endmodule

>>> rtl/c2d_mac.sv
// ---------------------------------------------------------------------------
// c2d_mac
// Two-stage multiply-accumulate with saturation of the final sum.
// ---------------------------------------------------------------------------
module c2d_mac import c2d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] sample,
  input  logic signed [VAL_W-1:0] weight,
  output mac_stat_t               stat
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     pl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  logic [ACC_W-SUM_W:0]     acc_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      pl_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pv_r   <= ctl.tap_valid;
      pl_r   <= ctl.tap_last;
      done_r <= pl_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample * weight;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // the sum fits when the guard bits all match the sign
  assign acc_top = acc_r[ACC_W-1:SUM_W-1];

  always_comb begin
    stat.done = done_r;
    if ((&acc_top) || !(|acc_top)) begin
      stat.sum = acc_r[SUM_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      stat.sum = SUM_MIN;
    end else begin
      stat.sum = SUM_MAX;
    end
  end

endmodule

>>> rtl/conv2d_forward_padded_strided.sv
// ---------------------------------------------------------------------------
// conv2d_forward_padded_strided
// Direct 2d cross-correlation of a multi-channel Q8.8 image with a bank of
// Q8.8 kernels, with zero padding and stride. Load requests write one image
// sample or one kernel weight and give no result. A compute request names a
// kernel and an output row and column and gives one result: the exact
// saturated Q.16 sum, or status 1 with a zero sum when the kernel or
// position is out of range. A compute steps one tap per cycle through the
// single read port of each store and the one multiply-accumulate; an
// out-of-range compute skips the taps. Padded taps are stepped through
// but not accumulated. A finished result waits in the output register
// while load requests go on.
// ---------------------------------------------------------------------------
module conv2d_forward_padded_strided import c2d_pkg::*; #(
  parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
  parameter int MAX_IMAGE_DIM  = DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNELS    = DEF_MAX_KERNELS,
  parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  c2d_in_if.sink                in_chan,
  c2d_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IMG_DEPTH = MAX_CHANNELS * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int WGT_DEPTH = MAX_KERNELS * MAX_CHANNELS * MAX_KERNEL_DIM * MAX_KERNEL_DIM;
  localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  cfg_t      cfg;
  in_req_t   req;
  mac_ctl_t  mac_ctl;
  mac_stat_t mac_stat;

  seq_state_t state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] c_r, c_nxt;
  logic [2:0] a_r, a_nxt;
  logic [2:0] b_r, b_nxt;
  logic signed [CRD_W-1:0] y0_r, y0_nxt;
  logic signed [CRD_W-1:0] x0_r, x0_nxt;
  logic err_r, err_nxt;
  logic rv_r, rv_nxt;
  logic rl_r, rl_nxt;
  logic out_valid_r, out_valid_nxt;
  out_res_t out_data_r, out_data_nxt;
  logic mac_clear;

  logic in_acc;
  logic img_we, wgt_we;
  logic [IAW-1:0] img_waddr, img_raddr;
  logic [WAW-1:0] wgt_waddr, wgt_raddr;
  logic signed [VAL_W-1:0] img_rdata, wgt_rdata;

  logic signed [CRD_W-1:0] span_h, span_w, row_st, col_st, tap_y, tap_x;
  logic range_ok, tap_in, tap_last;

  assign req = in_chan.data;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;

  c2d_cfg #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
    .MAX_KERNELS    (MAX_KERNELS),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // loads go straight into the stores; loads beyond the current sizes drop
  assign img_we = in_acc && (req.req_type == REQ_LOAD_IMG)
                  && ({1'b0, req.channel_sel} < cfg.nc)
                  && (req.row_pos < cfg.ih) && (req.col_pos < cfg.iw);
  assign wgt_we = in_acc && (req.req_type == REQ_LOAD_WGT)
                  && ({1'b0, req.kernel_sel} < cfg.nk)
                  && ({1'b0, req.channel_sel} < cfg.nc)
                  && (req.row_pos < 6'(cfg.kh)) && (req.col_pos < 6'(cfg.kw));

  assign img_waddr = IAW'((32'(req.channel_sel) * 32'(MAX_IMAGE_DIM) + 32'(req.row_pos))
                          * 32'(MAX_IMAGE_DIM) + 32'(req.col_pos));
  assign wgt_waddr = WAW'(((32'(req.kernel_sel) * 32'(MAX_CHANNELS) + 32'(req.channel_sel))
                           * 32'(MAX_KERNEL_DIM) + 32'(req.row_pos))
                          * 32'(MAX_KERNEL_DIM) + 32'(req.col_pos));

  // row < floor(span/stride)+1 is the same as row*stride <= span
  assign span_h = $signed(CRD_W'(cfg.ih)) + $signed(CRD_W'({cfg.pd, 1'b0}))
                  - $signed(CRD_W'(cfg.kh));
  assign span_w = $signed(CRD_W'(cfg.iw)) + $signed(CRD_W'({cfg.pd, 1'b0}))
                  - $signed(CRD_W'(cfg.kw));
  assign row_st = $signed(CRD_W'(req.row_pos) * CRD_W'(cfg.st));
  assign col_st = $signed(CRD_W'(req.col_pos) * CRD_W'(cfg.st));
  assign range_ok = ({1'b0, req.kernel_sel} < cfg.nk)
                    && !span_h[CRD_W-1] && (row_st <= span_h)
                    && !span_w[CRD_W-1] && (col_st <= span_w);

  // current tap, padded taps are skipped by the accumulator
  assign tap_y = y0_r + $signed(CRD_W'(a_r));
  assign tap_x = x0_r + $signed(CRD_W'(b_r));
  assign tap_in = !tap_y[CRD_W-1] && (tap_y < $signed(CRD_W'(cfg.ih)))
                  && !tap_x[CRD_W-1] && (tap_x < $signed(CRD_W'(cfg.iw)));
  assign tap_last = (c_r == cfg.nc - 3'd1) && (a_r == cfg.kh - 3'd1)
                    && (b_r == cfg.kw - 3'd1);

  assign img_raddr = IAW'((32'(c_r) * 32'(MAX_IMAGE_DIM) + 32'($unsigned(tap_y)))
                          * 32'(MAX_IMAGE_DIM) + 32'($unsigned(tap_x)));
  assign wgt_raddr = WAW'(((32'(k_r) * 32'(MAX_CHANNELS) + 32'(c_r))
                           * 32'(MAX_KERNEL_DIM) + 32'(a_r))
                          * 32'(MAX_KERNEL_DIM) + 32'(b_r));

  c2d_ram #(
    .WIDTH (VAL_W),
    .DEPTH (IMG_DEPTH)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (req.load_value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  c2d_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (req.load_value),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  assign mac_ctl.clear     = mac_clear;
  assign mac_ctl.tap_valid = rv_r;
  assign mac_ctl.tap_last  = rl_r;

  c2d_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (img_rdata),
    .weight (wgt_rdata),
    .stat   (mac_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    c_nxt         = c_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    y0_nxt        = y0_r;
    x0_nxt        = x0_r;
    err_nxt       = err_r;
    rv_nxt        = 1'b0;
    rl_nxt        = 1'b0;
    mac_clear     = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (req.req_type == REQ_COMPUTE)) begin
          k_nxt     = req.kernel_sel;
          c_nxt     = '0;
          a_nxt     = '0;
          b_nxt     = '0;
          y0_nxt    = row_st - $signed(CRD_W'(cfg.pd));
          x0_nxt    = col_st - $signed(CRD_W'(cfg.pd));
          err_nxt   = !range_ok;
          mac_clear = 1'b1;
          state_nxt = range_ok ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        rv_nxt = tap_in;
        rl_nxt = tap_last;
        if (b_r == cfg.kw - 3'd1) begin
          b_nxt = '0;
          if (a_r == cfg.kh - 3'd1) begin
            a_nxt = '0;
            c_nxt = c_r + 3'd1;
          end else begin
            a_nxt = a_r + 3'd1;
          end
        end else begin
          b_nxt = b_r + 3'd1;
        end
        if (tap_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_stat.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.conv_sum = err_r ? '0 : mac_stat.sum;
          out_data_nxt.status   = err_r ? STATUS_RANGE : STATUS_OK;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      rl_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      rl_r        <= rl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    c_r        <= c_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    y0_r       <= y0_nxt;
    x0_r       <= x0_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule
